### sv/tcw_pkg.sv
// Shared types, codes and sizing constants for the text console writer.
// No dependencies; tcw_front, tcw_back and the top level import this package.
package tcw_pkg;

	localparam int COLUMNS     = 80;
	localparam int ROWS        = 25;
	localparam int CELL_COUNT  = COLUMNS * ROWS;
	localparam int ADDR_W      = $clog2(CELL_COUNT);
	localparam int COL_W       = $clog2(COLUMNS);
	localparam int ROW_W       = $clog2(ROWS);
	localparam int POS_W       = 11;
	localparam int IDX_W       = 11;
	localparam int CELL_W      = 16;
	localparam int ATTR_W      = 8;
	localparam int CHAR_W      = 8;
	localparam int QDEPTH      = 2;
	localparam int QPTR_W      = $clog2(QDEPTH);

	localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
	localparam logic [CHAR_W-1:0] CH_RETURN    = 8'd13;
	localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
	localparam logic [CHAR_W-1:0] CH_SPACE     = 8'd32;
	localparam logic [ATTR_W-1:0] RESET_ATTR   = 8'h07;

	localparam logic [ADDR_W-1:0] LAST_ROW_POS = ADDR_W'((ROWS - 1) * COLUMNS);

	typedef enum logic [1:0] {
		REQ_PUT    = 2'd0,
		REQ_CLEAR  = 2'd1,
		REQ_READ   = 2'd2,
		REQ_UNUSED = 2'd3
	} req_type_t;

	typedef enum logic [2:0] {
		CMD_NONE,
		CMD_PUT,
		CMD_NEWLINE,
		CMD_RETURN,
		CMD_BACKSPACE,
		CMD_CLEAR,
		CMD_READ
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t         kind;
		logic [CHAR_W-1:0] ch;
		logic [ADDR_W-1:0] idx;
	} cmd_t;

	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} q_head_t;

	typedef struct packed {
		logic              strobe;
		logic [POS_W-1:0]  cursor_pos;
		logic [CELL_W-1:0] cell_word;
		logic              scrolled;
	} result_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ_WAIT,
		ST_SCROLL_COPY,
		ST_SCROLL_DRAIN,
		ST_SCROLL_BLANK,
		ST_SWEEP
	} state_t;

endpackage

### sv/tcw_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
// Self-contained; used for the screen cell store.
module tcw_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### sv/tcw_front.sv
// Front end of the console writer: accepts requests, classifies them into
// commands and holds them in a short queue. Depends on tcw_pkg.
module tcw_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [1:0]         req_type,
	input  logic [7:0]         char_code,
	input  logic [10:0]        cell_index,
	input  logic               hold,
	output logic               busy,
	output tcw_pkg::q_head_t   head,
	input  logic               pop
);

	import tcw_pkg::*;

	cmd_t              cmd_in;
	cmd_t              entry_q [QDEPTH];
	logic [QPTR_W-1:0] wptr_q;
	logic [QPTR_W-1:0] rptr_q;
	logic [QPTR_W:0]   count_q;
	logic              push;
	logic              in_range;

	assign in_range = 32'(cell_index) < CELL_COUNT;

	always_comb begin
		cmd_in.ch   = char_code;
		cmd_in.idx  = ADDR_W'(cell_index);
		cmd_in.kind = CMD_NONE;
		unique case (req_type_t'(req_type))
			REQ_PUT: begin
				unique case (char_code)
					CH_NEWLINE:   cmd_in.kind = CMD_NEWLINE;
					CH_RETURN:    cmd_in.kind = CMD_RETURN;
					CH_BACKSPACE: cmd_in.kind = CMD_BACKSPACE;
					default:      cmd_in.kind = CMD_PUT;
				endcase
			end
			REQ_CLEAR:  cmd_in.kind = CMD_CLEAR;
			REQ_READ:   cmd_in.kind = in_range ? CMD_READ : CMD_NONE;
			REQ_UNUSED: cmd_in.kind = CMD_NONE;
		endcase
	end

	assign busy       = (count_q == (QPTR_W + 1)'(QDEPTH)) || hold;
	assign push       = start && !busy;
	assign head.valid = count_q != '0;
	assign head.cmd   = entry_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wptr_q] <= cmd_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= (wptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= (rptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

### sv/tcw_back.sv
// Back end of the console writer: cursor state, the cell store and the
// sequencer for puts, reads, scrolls and clearing sweeps. Depends on tcw_pkg, tcw_ram.
module tcw_back (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic [7:0]               text_attr,
	input  tcw_pkg::q_head_t         head,
	output logic                     pop,
	output logic                     init_busy,
	output tcw_pkg::result_t         res
);

	import tcw_pkg::*;

	state_t            state_q, state_d;
	logic [ROW_W-1:0]  row_q, row_d;
	logic [COL_W-1:0]  col_q, col_d;
	logic [ADDR_W-1:0] pos_q, pos_d;
	logic [ADDR_W-1:0] idx_q, idx_d;
	logic [CELL_W-1:0] blank_q, blank_d;
	logic              rpt_q, rpt_d;
	logic              wr_pend_q, wr_pend_d;
	logic [ADDR_W-1:0] wr_addr_q, wr_addr_d;
	result_t           res_q, res_d;

	logic              we;
	logic [ADDR_W-1:0] waddr;
	logic [CELL_W-1:0] wdata;
	logic [ADDR_W-1:0] raddr;
	logic [CELL_W-1:0] rdata;

	cmd_t              hd;
	logic              at_last_col;
	logic              at_last_row;
	logic              needs_scroll;
	logic              copy_end;
	logic              sweep_end;
	logic [CELL_W-1:0] attr_blank;

	assign hd          = head.cmd;
	assign at_last_col = col_q == COL_W'(COLUMNS - 1);
	assign at_last_row = row_q == ROW_W'(ROWS - 1);
	assign needs_scroll = at_last_row &&
		((hd.kind == CMD_PUT && at_last_col) || hd.kind == CMD_NEWLINE);
	assign copy_end    = idx_q == ADDR_W'(CELL_COUNT - COLUMNS - 1);
	assign sweep_end   = idx_q == ADDR_W'(CELL_COUNT - 1);
	assign attr_blank  = {text_attr, CH_SPACE};
	assign init_busy   = (state_q == ST_SWEEP) && !rpt_q;
	assign res         = res_q;

	tcw_ram #(
		.WIDTH(CELL_W),
		.DEPTH(CELL_COUNT)
	) u_cells (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (head.valid) begin
					priority if (hd.kind == CMD_CLEAR) begin
						state_d = ST_SWEEP;
					end else if (hd.kind == CMD_READ) begin
						state_d = ST_READ_WAIT;
					end else if (needs_scroll) begin
						state_d = ST_SCROLL_COPY;
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			ST_READ_WAIT:    state_d = ST_IDLE;
			ST_SCROLL_COPY:  state_d = copy_end ? ST_SCROLL_DRAIN : ST_SCROLL_COPY;
			ST_SCROLL_DRAIN: state_d = ST_SCROLL_BLANK;
			ST_SCROLL_BLANK: state_d = sweep_end ? ST_IDLE : ST_SCROLL_BLANK;
			ST_SWEEP:        state_d = sweep_end ? ST_IDLE : ST_SWEEP;
			default:         state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		we        = 1'b0;
		waddr     = idx_q;
		wdata     = blank_q;
		raddr     = idx_q;
		pop       = 1'b0;
		row_d     = row_q;
		col_d     = col_q;
		pos_d     = pos_q;
		idx_d     = idx_q;
		blank_d   = blank_q;
		rpt_d     = rpt_q;
		wr_pend_d = wr_pend_q;
		wr_addr_d = wr_addr_q;
		res_d            = '0;
		res_d.cursor_pos = POS_W'(pos_q);
		unique case (state_q)
			ST_IDLE: begin
				if (head.valid) begin
					pop = 1'b1;
					unique case (hd.kind)
						CMD_PUT: begin
							we    = 1'b1;
							waddr = pos_q;
							wdata = {text_attr, hd.ch};
							if (at_last_col) begin
								col_d = '0;
								if (at_last_row) begin
									pos_d     = LAST_ROW_POS;
									idx_d     = '0;
									wr_pend_d = 1'b0;
								end else begin
									row_d = row_q + 1'b1;
									pos_d = pos_q + 1'b1;
								end
							end else begin
								col_d = col_q + 1'b1;
								pos_d = pos_q + 1'b1;
							end
						end
						CMD_NEWLINE: begin
							col_d = '0;
							if (at_last_row) begin
								pos_d     = LAST_ROW_POS;
								idx_d     = '0;
								wr_pend_d = 1'b0;
							end else begin
								row_d = row_q + 1'b1;
								pos_d = pos_q - ADDR_W'(col_q) + ADDR_W'(COLUMNS);
							end
						end
						CMD_RETURN: begin
							col_d = '0;
							pos_d = pos_q - ADDR_W'(col_q);
						end
						CMD_BACKSPACE: begin
							if (col_q != '0) begin
								we    = 1'b1;
								waddr = pos_q - 1'b1;
								wdata = attr_blank;
								col_d = col_q - 1'b1;
								pos_d = pos_q - 1'b1;
							end
						end
						CMD_CLEAR: begin
							blank_d = attr_blank;
							idx_d   = '0;
							rpt_d   = 1'b1;
							row_d   = '0;
							col_d   = '0;
							pos_d   = '0;
						end
						CMD_READ: begin
							raddr = hd.idx;
						end
						default: begin
						end
					endcase
					res_d.strobe = !(hd.kind == CMD_CLEAR || hd.kind == CMD_READ || needs_scroll);
					res_d.cursor_pos = POS_W'(pos_d);
				end
			end
			ST_READ_WAIT: begin
				res_d.strobe    = 1'b1;
				res_d.cell_word = rdata;
			end
			ST_SCROLL_COPY: begin
				raddr     = idx_q + ADDR_W'(COLUMNS);
				we        = wr_pend_q;
				waddr     = wr_addr_q;
				wdata     = rdata;
				wr_pend_d = 1'b1;
				wr_addr_d = idx_q;
				idx_d     = idx_q + 1'b1;
			end
			ST_SCROLL_DRAIN: begin
				we        = 1'b1;
				waddr     = wr_addr_q;
				wdata     = rdata;
				wr_pend_d = 1'b0;
				idx_d     = ADDR_W'(CELL_COUNT - COLUMNS);
			end
			ST_SCROLL_BLANK: begin
				we    = 1'b1;
				waddr = idx_q;
				wdata = attr_blank;
				idx_d = idx_q + 1'b1;
				if (sweep_end) begin
					res_d.strobe   = 1'b1;
					res_d.scrolled = 1'b1;
				end
			end
			ST_SWEEP: begin
				we    = 1'b1;
				waddr = idx_q;
				wdata = blank_q;
				idx_d = idx_q + 1'b1;
				res_d.strobe = sweep_end && rpt_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		wr_addr_q <= wr_addr_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_SWEEP;
			row_q     <= '0;
			col_q     <= '0;
			pos_q     <= '0;
			idx_q     <= '0;
			blank_q   <= {RESET_ATTR, CH_SPACE};
			rpt_q     <= 1'b0;
			wr_pend_q <= 1'b0;
			res_q     <= '0;
		end else begin
			state_q   <= state_d;
			row_q     <= row_d;
			col_q     <= col_d;
			pos_q     <= pos_d;
			idx_q     <= idx_d;
			blank_q   <= blank_d;
			rpt_q     <= rpt_d;
			wr_pend_q <= wr_pend_d;
			res_q     <= res_d;
		end
	end

	a_pos_matches_cursor: assert property (@(posedge clk) disable iff (!arst_n)
		32'(pos_q) == 32'(row_q) * COLUMNS + 32'(col_q))
		else $error("linear cursor position disagrees with row and column");

	a_write_in_grid: assert property (@(posedge clk) disable iff (!arst_n)
		we |-> 32'(waddr) < CELL_COUNT)
		else $error("cell write outside the grid");

	a_no_result_in_init: assert property (@(posedge clk) disable iff (!arst_n)
		init_busy |=> !res_q.strobe)
		else $error("result issued during the reset clearing pass");

	a_scroll_on_last_row: assert property (@(posedge clk) disable iff (!arst_n)
		(res_q.strobe && res_q.scrolled) |-> row_q == ROW_W'(ROWS - 1))
		else $error("scrolled result with cursor off the last row");

	a_no_pop_in_init: assert property (@(posedge clk) disable iff (!arst_n)
		init_busy |-> !pop)
		else $error("command taken during the reset clearing pass");

endmodule

### sv/text_console_writer_unit.sv
// Top level of the text console writer: attribute register, front end and
// back end. Depends on tcw_pkg, tcw_front, tcw_back.
//
// A request is taken at a rising edge with start high and busy low. Each
// request gives one result, shown for one cycle with done high; the
// receiver must take it then. Results come in request order.
// Put, return, backspace and unused requests: the request is queued, then
// its result is registered; one put per cycle unless a read, scroll or clear
// stalls the back end. Read: its result also waits for the registered read
// of the cell store. A put or newline that scrolls copies the grid up one row
// and blanks the bottom row before its result.
// A clear sweeps every cell before its result.
// A two-entry queue lets requests be taken while a sweep runs; busy rises
// when it is full.
// After reset a clearing pass fills the grid with attribute 0x07 spaces; busy is
// high during it. The attribute register accepts writes at any time on its own
// valid/ready channel.
module text_console_writer_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  req_type,
	input  logic [7:0]  char_code,
	input  logic [10:0] cell_index,
	output logic        done,
	output logic [10:0] cursor_pos,
	output logic [15:0] cell_word,
	output logic        scrolled,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_data
);

	import tcw_pkg::*;

	logic [ATTR_W-1:0] text_attr_q;
	q_head_t           head;
	logic              pop;
	logic              init_busy;
	result_t           res;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			text_attr_q <= RESET_ATTR;
		end else if (cfg_valid && cfg_ready) begin
			text_attr_q <= cfg_data;
		end
	end

	tcw_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.req_type  (req_type),
		.char_code (char_code),
		.cell_index(cell_index),
		.hold      (init_busy),
		.busy      (busy),
		.head      (head),
		.pop       (pop)
	);

	tcw_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.text_attr(text_attr_q),
		.head     (head),
		.pop      (pop),
		.init_busy(init_busy),
		.res      (res)
	);

	assign done       = res.strobe;
	assign cursor_pos = res.cursor_pos;
	assign cell_word  = res.cell_word;
	assign scrolled   = res.scrolled;

endmodule
